// ----- src/sensor_scratchpad_crc_checker_assert.svh -----
// Assertion macros used by the checker file of this block.
`ifndef SENSOR_SCRATCHPAD_CRC_CHECKER_ASSERT_SVH
`define SENSOR_SCRATCHPAD_CRC_CHECKER_ASSERT_SVH

// Clocked assertion that is switched off while reset is high.
`define SSCC_ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define SSCC_ASSERT(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/sscc_pkg.sv -----
`default_nettype none

package sscc_pkg;

   // Number of scratchpad bytes covered by the CRC; the check byte follows them.
   localparam int DATA_BYTES = 8;
   localparam int IDX_W      = $clog2(DATA_BYTES + 1);

   // Reflected CRC-8 polynomial.
   localparam logic [7:0] CRC_POLY = 8'h8C;

   // Configuration port.
   localparam int          CSR_ADDR_W      = 3;
   localparam logic        REG_TEMP_OFFSET = 1'b0;

   // Rounding and conversion constants, in sixteenths of a degree.
   localparam logic [15:0] DEG_ROUND = 16'd8;
   localparam logic [15:0] F_BIAS    = 16'd520;   // 32 degrees F plus rounding
   // 52429 / 2^18 is one fifth, exact after truncation for 16-bit magnitudes.
   localparam logic [16:0] RECIP5    = 17'd52429;
   localparam int          RECIP5_SH = 18;

   // Result of one byte as seen by the frame tracker.
   typedef struct packed {
      logic        check;    // this byte was the check byte
      logic        crc_ok;
      logic [15:0] temp;     // stored temperature after this byte
   } frame_res_type;

   // One byte through the reflected CRC-8, least significant bit first.
   function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      logic       mix;
      c = crc;
      for (int k = 0; k < 8; k++) begin
         mix = c[0] ^ b[k];
         c   = {1'b0, c[7:1]};
         if (mix) begin
            c = c ^ CRC_POLY;
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ----- src/sscc_frame.sv -----
`default_nettype none

module sscc_frame (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  xfer,
   input  wire logic [7:0]            data_byte,
   input  wire logic                  frame_start,
   input  wire logic [15:0]           temp_offset,
   output sscc_pkg::frame_res_type    res
);
   import sscc_pkg::*;

   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [7:0]       crc_ff, crc_in;
   logic [15:0]      raw_ff, raw_in;
   logic [15:0]      stored_ff, stored_in;

   logic [IDX_W-1:0] idx;
   logic [7:0]       crc;
   logic [15:0]      raw;
   logic [15:0]      accepted;
   logic             is_check;
   logic             ok;

   // A start flag makes this byte the first one of a fresh frame.
   always_comb begin
      idx      = frame_start ? '0 : idx_ff;
      crc      = frame_start ? '0 : crc_ff;
      raw      = frame_start ? '0 : raw_ff;
      is_check = (idx >= IDX_W'(DATA_BYTES));
      ok       = (data_byte == crc);
      accepted = raw + temp_offset;
   end

   // Frame state update on each input transfer.
   always_comb begin
      idx_in    = idx_ff;
      crc_in    = crc_ff;
      raw_in    = raw_ff;
      stored_in = stored_ff;
      if (xfer) begin
         if (!is_check) begin
            raw_in = raw;
            if (idx == IDX_W'(0)) begin
               raw_in[7:0] = data_byte;
            end else if (idx == IDX_W'(1)) begin
               raw_in[15:8] = data_byte;
            end
            crc_in = crc8_feed(crc, data_byte);
            idx_in = idx + IDX_W'(1);
         end else begin
            idx_in = '0;
            crc_in = '0;
            raw_in = '0;
            if (ok) begin
               stored_in = accepted;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff    <= '0;
         crc_ff    <= '0;
         raw_ff    <= '0;
         stored_ff <= '0;
      end else begin
         idx_ff    <= idx_in;
         crc_ff    <= crc_in;
         raw_ff    <= raw_in;
         stored_ff <= stored_in;
      end
   end

   // Result of the current byte; only meaningful on a check byte.
   always_comb begin
      res.check  = is_check;
      res.crc_ok = ok;
      res.temp   = ok ? accepted : stored_ff;
   end

endmodule

`default_nettype wire

// ----- src/sensor_scratchpad_crc_checker.sv -----
// Channel   Direction  tdata                          tuser
// req       in         data_byte[7:0]                 frame_start
// rsp       out        temperature, deg_c, deg_f      crc_ok
// csr       in/out     APB register port, temp_offset at byte address 0
//
// One byte is taken in every cycle while req_tready is high; the frame tracker
// updates its state in the cycle of the transfer. A check byte yields a result
// through one register after the frame tracker, one after the 16x17 reciprocal
// multiplier of the Fahrenheit conversion. Other bytes yield no result.
// Synchronous reset clears the frame, the stored temperature and the offset.
// A stall on rsp holds both stages; req stays ready while a stage is free.
`default_nettype none

module sensor_scratchpad_crc_checker (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // Input bytes.
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [7:0]                     req_tdata,   // data_byte[7:0]
   input  wire logic                           req_tuser,   // frame_start
   // Results.
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic [39:0]                         rsp_tdata,   // temperature[15:0],
                                                            // deg_c[27:16], deg_f[39:28]
   output logic                                rsp_tuser,   // crc_ok
   // Configuration.
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [sscc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]                    csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready
);
   import sscc_pkg::*;

   logic [15:0]   offset_ff, offset_in;
   logic          s1_valid_ff, s1_valid_in;
   logic          s1_ok_ff, s1_ok_in;
   logic [15:0]   s1_temp_ff, s1_temp_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [39:0]   rsp_data_ff, rsp_data_in;
   logic          rsp_ok_ff, rsp_ok_in;

   logic          s1_adv;
   logic          s2_adv;
   logic          xfer;
   logic          csr_wr;
   frame_res_type res;

   // Configuration register.
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      offset_in = offset_ff;
      if (csr_wr && csr_paddr[2] == REG_TEMP_OFFSET) begin
         offset_in = csr_pwdata[15:0];
      end
      if (csr_paddr[2] == REG_TEMP_OFFSET) begin
         csr_prdata = {{16{offset_ff[15]}}, offset_ff};
      end else begin
         csr_prdata = '0;
      end
   end

   // Pipeline flow control.
   assign s2_adv     = !rsp_valid_ff || rsp_tready;
   assign s1_adv     = !s1_valid_ff || s2_adv;
   assign req_tready = s1_adv;
   assign xfer       = req_tvalid & req_tready;

   sscc_frame u_frame (
      .clock       (clock),
      .reset       (reset),
      .xfer        (xfer),
      .data_byte   (req_tdata),
      .frame_start (req_tuser),
      .temp_offset (offset_ff),
      .res         (res)
   );

   // First stage: the result of a check byte.
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_ok_in    = s1_ok_ff;
      s1_temp_in  = s1_temp_ff;
      if (s1_adv) begin
         s1_valid_in = xfer & res.check;
         s1_ok_in    = res.crc_ok;
         s1_temp_in  = res.temp;
      end
   end

   // Second stage: rounding and conversion to whole degrees.
   always_comb begin
      logic [15:0] mag;
      logic [32:0] prod;
      logic [15:0] qmag;
      logic [15:0] q16;
      logic [15:0] f16;
      logic [15:0] c16;
      mag  = s1_temp_ff[15] ? 16'(-s1_temp_ff) : s1_temp_ff;
      prod = 33'(mag) * 33'(RECIP5);
      qmag = 16'(prod[32:RECIP5_SH]);
      q16  = s1_temp_ff[15] ? 16'(-qmag) : qmag;
      f16  = {q16[12:0], 3'b000} + q16 + F_BIAS;
      c16  = s1_temp_ff + DEG_ROUND;

      rsp_valid_in = rsp_valid_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_data_in  = rsp_data_ff;
      if (s2_adv) begin
         rsp_valid_in = s1_valid_ff;
         rsp_ok_in    = s1_ok_ff;
         rsp_data_in  = {f16[15:4], c16[15:4], s1_temp_ff};
      end
   end

   // Control state with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff    <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         offset_ff    <= offset_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      s1_ok_ff    <= s1_ok_in;
      s1_temp_ff  <= s1_temp_in;
      rsp_ok_ff   <= rsp_ok_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_ok_ff;

endmodule

`default_nettype wire

// ----- src/sscc_checker.sv -----
`default_nettype none

`include "sensor_scratchpad_crc_checker_assert.svh"

module sscc_checker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   input  wire logic                            req_tready,
   input  wire logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   input  wire logic [39:0]                     rsp_tdata,
   input  wire logic                            rsp_tuser,
   input  wire logic                            csr_pready
);
   import sscc_pkg::*;

   logic        xfer;
   logic        rsp_stall;
   logic [40:0] rsp_word;
   logic [15:0] c_chk;
   logic        c_match;

   assign xfer      = req_tvalid & req_tready;
   assign rsp_stall = rsp_tvalid & !rsp_tready;
   assign rsp_word  = {rsp_tuser, rsp_tdata};
   assign c_chk     = rsp_tdata[15:0] + DEG_ROUND;
   assign c_match   = (rsp_tdata[27:16] == c_chk[15:4]);

   // A pending result is not withdrawn or changed while stalled.
   `SSCC_ASSERT_RST(a_rsp_hold, clock, reset, rsp_stall |=> rsp_tvalid, "rsp_tvalid dropped")
   `SSCC_ASSERT_RST(a_rsp_stable, clock, reset, rsp_stall |=> $stable(rsp_word), "rsp changed")

   // A new result appears only after a byte transfer, through both stage registers.
   `SSCC_ASSERT_RST(a_latency, clock, reset, $rose(rsp_tvalid) |-> $past(xfer, 2), "stray result")

   // Celsius rounding agrees with the reported temperature.
   `SSCC_ASSERT_RST(a_deg_c, clock, reset, rsp_tvalid |-> c_match, "deg_c mismatch")

   // The register port never inserts wait states.
   `SSCC_ASSERT(a_pready, clock, csr_pready, "csr_pready low")

endmodule

bind sensor_scratchpad_crc_checker sscc_checker u_sscc_checker (.*);

`default_nettype wire

// ----- tb/tb_sensor_scratchpad_crc_checker.sv -----
`timescale 1ns / 1ps

module tb_sensor_scratchpad_crc_checker;

   localparam int IDLE_LIMIT    = 1000;
   localparam int SETTLE_CYCLES = 6;
   localparam int HOLD_CYCLES   = 120;
   localparam int FRAME_BYTES   = sscc_pkg::DATA_BYTES;

   localparam logic [7:0]  CRC8_POLY  = 8'h8C;
   localparam logic [15:0] HALF_DEG   = 16'd8;
   // 32 degrees Fahrenheit in sixteenths, plus half a degree for rounding.
   localparam logic [15:0] FAHR_BIAS  = 16'd520;
   localparam logic [sscc_pkg::CSR_ADDR_W-1:0] TEMP_OFFSET_ADDR =
      sscc_pkg::CSR_ADDR_W'(4 * int'(sscc_pkg::REG_TEMP_OFFSET));

   // One expected result of a check byte.
   typedef struct packed {
      logic        crc_ok;
      logic [15:0] temp;
      logic [11:0] deg_c;
      logic [11:0] deg_f;
   } reading_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // data_byte[7:0]
   logic        req_tuser = 1'b0;    // frame_start
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;           // temperature[15:0], deg_c[27:16], deg_f[39:28]
   logic        rsp_tuser;           // crc_ok
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [sscc_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = 32'h0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // Predicted scratchpad state and configuration.
   reading_type expected_readings[$];
   logic [3:0]  sp_index;
   logic [7:0]  sp_crc;
   logic [15:0] sp_raw;
   logic [15:0] sp_stored;
   logic [15:0] cal_offset;

   int error_count = 0;
   int bytes_sent = 0;
   bit idling_on = 1'b1;
   int rsp_hold_request = 0;
   int rsp_hold_left = 0;
   int rsp_stall_left = 0;
   int idle_cycles = 0;

   sensor_scratchpad_crc_checker uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Reflected CRC-8, one byte taken least significant bit first.
   function automatic logic [7:0] crc8_reflected_byte(input logic [7:0] crc,
                                                      input logic [7:0] b);
      logic [7:0] acc;
      logic       fb;
      acc = crc;
      for (int i = 0; i < 8; i++) begin
         fb  = acc[0] ^ b[i];
         acc = (acc >> 1) ^ ({8{fb}} & CRC8_POLY);
      end
      return acc;
   endfunction

   function automatic void clear_frame_state();
      sp_index = 4'd0;
      sp_crc   = 8'h00;
      sp_raw   = 16'h0000;
   endfunction

   // Advances the predicted state by one byte and queues a reading on a check byte.
   function automatic void absorb_byte(input logic [7:0] b, input logic start);
      reading_type r;
      logic [15:0] c16;
      logic [15:0] f16;
      int          fifth;
      if (start) begin
         clear_frame_state();
      end
      if (sp_index < FRAME_BYTES) begin
         if (sp_index == 4'd0) begin
            sp_raw[7:0] = b;
         end else if (sp_index == 4'd1) begin
            sp_raw[15:8] = b;
         end
         sp_crc   = crc8_reflected_byte(sp_crc, b);
         sp_index = sp_index + 4'd1;
      end else begin
         r.crc_ok = (b == sp_crc);
         if (r.crc_ok) begin
            sp_stored = sp_raw + cal_offset;
         end
         clear_frame_state();
         r.temp  = sp_stored;
         c16     = sp_stored + HALF_DEG;
         fifth   = int'($signed(sp_stored)) / 5;
         f16     = 16'(fifth * 9) + FAHR_BIAS;
         r.deg_c = c16[15:4];
         r.deg_f = f16[15:4];
         expected_readings.push_back(r);
      end
   endfunction

   task automatic report_mismatch(input string msg);
      error_count++;
      $display("MISMATCH at %0t: %s", $realtime, msg);
   endtask

   // Compares each result transfer with the oldest predicted reading.
   always @(posedge clock) begin
      reading_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_readings.size() == 0) begin
            report_mismatch($sformatf("unexpected result, temperature %h", rsp_tdata[15:0]));
         end else begin
            want = expected_readings.pop_front();
            if (rsp_tuser !== want.crc_ok) begin
               report_mismatch($sformatf("crc_ok %b, expected %b", rsp_tuser, want.crc_ok));
            end
            if (rsp_tdata[15:0] !== want.temp) begin
               report_mismatch($sformatf("temperature %h, expected %h",
                                         rsp_tdata[15:0], want.temp));
            end
            if (rsp_tdata[27:16] !== want.deg_c) begin
               report_mismatch($sformatf("deg_c %h, expected %h",
                                         rsp_tdata[27:16], want.deg_c));
            end
            if (rsp_tdata[39:28] !== want.deg_f) begin
               report_mismatch($sformatf("deg_f %h, expected %h",
                                         rsp_tdata[39:28], want.deg_f));
            end
         end
      end
   end

   // Result receiver: long hold-offs on request, otherwise random stall bursts while idling is on.
   always @(negedge clock) begin
      if (rsp_hold_request > 0) begin
         rsp_hold_left    = rsp_hold_request;
         rsp_hold_request = 0;
      end
      if (rsp_hold_left > 0) begin
         rsp_hold_left--;
         rsp_tready <= 1'b0;
      end else if (rsp_stall_left > 0) begin
         rsp_stall_left--;
         rsp_tready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
         rsp_stall_left = $urandom_range(0, 4);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Watchdog: ends the run when no transfer happens for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable && csr_pready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Watchdog: no transfer for %0d cycles", IDLE_LIMIT);
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // Offers one byte, with an optional gap first, and waits for its transfer.
   task automatic send_scratch_byte(input logic [7:0] b, input logic start);
      int gap;
      gap = (idling_on && $urandom_range(0, 7) == 0) ? $urandom_range(1, 5) : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= start;
      do @(posedge clock); while (!req_tready);
      absorb_byte(b, start);
      bytes_sent++;
   endtask

   // Sends a whole scratchpad: the data bytes and then the check byte.
   task automatic send_scratchpad(input logic [15:0] raw, input bit use_start,
                                  input bit bad_crc);
      logic [7:0] pad [FRAME_BYTES + 1];
      logic [7:0] crc;
      pad[0] = raw[7:0];
      pad[1] = raw[15:8];
      for (int i = 2; i < FRAME_BYTES; i++) begin
         pad[i] = 8'($urandom);
      end
      crc = 8'h00;
      for (int i = 0; i < FRAME_BYTES; i++) begin
         crc = crc8_reflected_byte(crc, pad[i]);
      end
      pad[FRAME_BYTES] = bad_crc ? (crc ^ 8'($urandom_range(1, 255))) : crc;
      for (int i = 0; i <= FRAME_BYTES; i++) begin
         send_scratch_byte(pad[i], use_start && (i == 0));
      end
   endtask

   // Random bytes: a started partial frame, or noise with random start flags.
   task automatic send_loose_bytes(input int n, input bit random_starts);
      for (int i = 0; i < n; i++) begin
         send_scratch_byte(8'($urandom),
                           random_starts ? 1'($urandom_range(0, 1)) : (i == 0));
      end
   endtask

   // Stops offering bytes until every predicted reading has arrived.
   task automatic wait_readings_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_readings.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes the offset register and reads it back.
   task automatic write_temp_offset(input logic [15:0] value);
      logic [31:0] rd;
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= TEMP_OFFSET_ADDR;
      csr_pwdata  <= {{16{value[15]}}, value};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      cal_offset = value;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rd = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (rd[15:0] !== value) begin
         report_mismatch($sformatf("temp_offset read %h, expected %h", rd[15:0], value));
      end
   endtask

   function automatic logic [15:0] random_raw();
      case ($urandom_range(0, 3))
         0: return 16'($urandom);
         1: return 16'($urandom_range(0, 2880)) - 16'd880;
         2: return 16'($urandom_range(0, 160)) - 16'd80;
         default: begin
            case ($urandom_range(0, 5))
               0: return 16'h7FFF;
               1: return 16'h8000;
               2: return 16'hFFFF;
               3: return 16'h0000;
               4: return 16'h0008;
               default: return 16'hFFF8;
            endcase
         end
      endcase
   endfunction

   // A dropped partial frame, a good frame and a frame with a bad check byte.
   task automatic test_directed_frames();
      send_loose_bytes(3, 1'b0);
      send_scratchpad(16'h0191, 1'b1, 1'b0);
      send_scratchpad(16'hFE6F, 1'b0, 1'b1);
      wait_readings_drained();
   endtask

   // Offset extremes against raw extremes, so that some of the sums wrap.
   task automatic test_offset_extremes();
      logic [15:0] offsets [4] = '{16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000};
      foreach (offsets[k]) begin
         write_temp_offset(offsets[k]);
         send_scratchpad(16'h7FFF, 1'b1, 1'b0);
         send_scratchpad(16'h8000, 1'b1, 1'b0);
         send_scratchpad(16'($urandom_range(0, 40)) - 16'd20, 1'b1, 1'b0);
         wait_readings_drained();
      end
   endtask

   // Mostly good frames, with bad check bytes, restarts, noise, pauses and new offsets.
   task automatic test_random_frames(input int target);
      int choice;
      while (bytes_sent < target) begin
         choice = $urandom_range(0, 99);
         if (choice < 65) begin
            send_scratchpad(random_raw(), (sp_index != 4'd0) || ($urandom_range(0, 3) != 0),
                            1'b0);
         end else if (choice < 77) begin
            send_scratchpad(random_raw(), 1'b1, 1'b1);
         end else if (choice < 87) begin
            send_loose_bytes($urandom_range(1, FRAME_BYTES), 1'b0);
         end else if (choice < 93) begin
            send_loose_bytes($urandom_range(1, 3), 1'b1);
         end else if (choice < 97) begin
            wait_readings_drained();
         end else begin
            wait_readings_drained();
            write_temp_offset(($urandom_range(0, 3) == 0) ? 16'($urandom) :
                              16'($urandom_range(0, 128)) - 16'd64);
         end
      end
      wait_readings_drained();
   endtask

   // The receiver holds off while frames keep coming, so the input must stall.
   task automatic test_output_stall();
      idling_on = 1'b0;
      rsp_hold_request = HOLD_CYCLES;
      repeat (8) send_scratchpad(random_raw(), 1'b1, 1'b0);
      wait_readings_drained();
      idling_on = 1'b1;
   endtask

   // Full rate on both sides to close the run.
   task automatic test_back_to_back();
      idling_on = 1'b0;
      repeat (6) send_scratchpad(random_raw(), 1'b1, 1'($urandom_range(0, 3) == 0));
      wait_readings_drained();
   endtask

   initial begin
      sp_stored  = 16'h0000;
      cal_offset = 16'h0000;
      clear_frame_state();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_frames();
      test_offset_extremes();
      test_random_frames(430);
      test_output_stall();
      test_back_to_back();

      if (expected_readings.size() != 0) begin
         report_mismatch($sformatf("%0d readings never arrived", expected_readings.size()));
      end
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+src
src/sscc_pkg.sv
src/sscc_frame.sv
src/sensor_scratchpad_crc_checker.sv
src/sscc_checker.sv
tb/tb_sensor_scratchpad_crc_checker.sv
